@@ sv/ecfe_pkg.sv @@
// Shared types and byte constants for the escaped command frame encoder.
`default_nettype none

package ecfe_pkg;

    localparam logic [7:0] CODE_WRITE = 8'h77;
    localparam logic [7:0] BYTE_ESC   = 8'hDB;
    localparam logic [7:0] ESC_LF     = 8'hDC;
    localparam logic [7:0] ESC_ESC    = 8'hDD;
    localparam logic [7:0] LINE_END   = 8'h0A;

    localparam logic CMD_HEADER  = 1'b0;
    localparam logic CMD_PAYLOAD = 1'b1;

    localparam int JOB_BYTES = 4;

    typedef struct packed {
        logic [JOB_BYTES-1:0][7:0] bytes;
        logic [1:0]                last_idx;
        logic                      hdr;
        logic                      trailer;
    } t_job;

endpackage

`default_nettype wire

@@ sv/ecfe_front.sv @@
// Front end: accepts input beats, tracks expected payload and builds encode jobs.
`default_nettype none

module ecfe_front (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         push,
    input  wire logic         i_q_full,
    input  wire logic         i_cmd,
    input  wire logic [7:0]   i_command_code,
    input  wire logic [7:0]   i_page_count,
    input  wire logic [15:0]  i_address,
    input  wire logic [7:0]   i_data_byte,
    output ecfe_pkg::t_job    o_job,
    output logic              o_job_push
);

    logic [8:0] r_left;
    logic [8:0] n_left;
    logic       accept;
    logic       is_write;

    assign accept   = push && !i_q_full;
    assign is_write = (i_command_code == ecfe_pkg::CODE_WRITE);

    always_comb begin
        n_left     = r_left;
        o_job_push = 1'b0;
        o_job      = '0;
        if (i_cmd == ecfe_pkg::CMD_HEADER) begin
            o_job.bytes    = {i_address[7:0], i_address[15:8], i_page_count, i_command_code};
            o_job.last_idx = 2'd3;
            o_job.hdr      = 1'b1;
            o_job.trailer  = !is_write;
            if (accept) begin
                o_job_push = 1'b1;
                n_left     = is_write ? ({1'b0, i_page_count} + 9'd1) : 9'd0;
            end
        end else begin
            o_job.bytes[0] = i_data_byte;
            o_job.last_idx = 2'd0;
            o_job.hdr      = 1'b0;
            o_job.trailer  = (r_left == 9'd1);
            if (accept && r_left != 9'd0) begin
                o_job_push = 1'b1;
                n_left     = r_left - 9'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left <= '0;
        end else begin
            r_left <= n_left;
        end
    end

endmodule

`default_nettype wire

@@ sv/ecfe_fifo.sv @@
// Short job queue between the front end and the byte serializer.
`default_nettype none

module ecfe_fifo #(
    parameter int DEPTH = 4
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_wr,
    input  wire ecfe_pkg::t_job i_wr_job,
    input  wire logic           i_rd,
    output ecfe_pkg::t_job      o_rd_job,
    output logic                o_valid,
    output logic                o_full
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    ecfe_pkg::t_job   r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             wr_en;
    logic             rd_en;

    assign o_valid  = (r_count != '0);
    assign o_full   = (r_count == CNT_W'(DEPTH));
    assign wr_en    = i_wr && !o_full;
    assign rd_en    = i_rd && o_valid;
    assign o_rd_job = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr_ptr] <= i_wr_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (wr_en) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(r_wr_ptr + 1'b1);
            end
            if (rd_en) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(r_rd_ptr + 1'b1);
            end
            if (wr_en && !rd_en) begin
                r_count <= CNT_W'(r_count + 1'b1);
            end else if (rd_en && !wr_en) begin
                r_count <= CNT_W'(r_count - 1'b1);
            end
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("job queue count exceeds its depth");

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full && !rd_en |=> o_full)
        else $error("job queue left full without a read");

    a_ptr_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) |-> (r_wr_ptr == r_rd_ptr))
        else $error("job queue pointers differ while empty");

endmodule

`default_nettype wire

@@ sv/ecfe_back.sv @@
// Back end: escapes job bytes, keeps the running sum, appends the trailer, holds the result.
`default_nettype none

module ecfe_back (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire ecfe_pkg::t_job i_job,
    input  wire logic           i_job_valid,
    output logic                o_job_pop,
    input  wire logic           pop,
    output logic                empty,
    output logic [7:0]          o_out_byte,
    output logic                o_frame_last,
    output logic                o_run_last
);

    typedef enum logic [3:0] {
        ST_DATA = 4'b0001,
        ST_ESC  = 4'b0010,
        ST_CHK  = 4'b0100,
        ST_LF   = 4'b1000
    } t_state;

    t_state     r_state;
    t_state     n_state;
    logic [1:0] r_idx;
    logic [1:0] n_idx;
    logic [7:0] r_sum;
    logic [7:0] n_sum;
    logic       r_out_valid;
    logic [7:0] r_out_byte;
    logic       r_frame_last;
    logic       r_run_last;

    logic       out_ready;
    logic       emit;
    logic [7:0] e_byte;
    logic       e_frame_last;
    logic       e_run_last;
    logic       end_byte;
    logic [7:0] cur;
    logic       special;
    logic [7:0] base;
    logic [7:0] chk;

    assign out_ready = !r_out_valid || pop;
    assign cur       = i_job.bytes[r_idx];
    assign special   = (cur == ecfe_pkg::LINE_END) || (cur == ecfe_pkg::BYTE_ESC);
    assign base      = (i_job.hdr && r_idx == 2'd0) ? 8'h00 : r_sum;
    assign chk       = 8'h00 - r_sum;

    always_comb begin
        n_state      = r_state;
        n_idx        = r_idx;
        n_sum        = r_sum;
        emit         = 1'b0;
        e_byte       = '0;
        e_frame_last = 1'b0;
        e_run_last   = 1'b0;
        end_byte     = 1'b0;
        o_job_pop    = 1'b0;
        if (i_job_valid && out_ready) begin
            emit = 1'b1;
            unique case (r_state)
                ST_DATA: begin
                    if (special) begin
                        e_byte  = ecfe_pkg::BYTE_ESC;
                        n_state = ST_ESC;
                    end else begin
                        e_byte   = cur;
                        end_byte = 1'b1;
                    end
                    n_sum = base + e_byte;
                end
                ST_ESC: begin
                    e_byte   = (cur == ecfe_pkg::LINE_END) ? ecfe_pkg::ESC_LF
                                                           : ecfe_pkg::ESC_ESC;
                    n_sum    = r_sum + e_byte;
                    end_byte = 1'b1;
                end
                ST_CHK: begin
                    e_byte = chk;
                    if (chk == ecfe_pkg::LINE_END) begin
                        e_frame_last = 1'b1;
                        e_run_last   = 1'b1;
                        o_job_pop    = 1'b1;
                        n_state      = ST_DATA;
                    end else begin
                        n_state = ST_LF;
                    end
                end
                ST_LF: begin
                    e_byte       = ecfe_pkg::LINE_END;
                    e_frame_last = 1'b1;
                    e_run_last   = 1'b1;
                    o_job_pop    = 1'b1;
                    n_state      = ST_DATA;
                end
                default: begin
                    n_state = ST_DATA;
                end
            endcase
            if (end_byte) begin
                if (r_idx == i_job.last_idx) begin
                    if (i_job.trailer) begin
                        n_state = ST_CHK;
                    end else begin
                        e_run_last = 1'b1;
                        o_job_pop  = 1'b1;
                        n_state    = ST_DATA;
                    end
                end else begin
                    n_idx   = 2'(r_idx + 2'd1);
                    n_state = ST_DATA;
                end
            end
            if (o_job_pop) begin
                n_idx = 2'd0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_DATA;
            r_idx       <= '0;
            r_sum       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_sum   <= n_sum;
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_byte   <= e_byte;
            r_frame_last <= e_frame_last;
            r_run_last   <= e_run_last;
        end
    end

    assign empty        = !r_out_valid;
    assign o_out_byte   = r_out_byte;
    assign o_frame_last = r_frame_last;
    assign o_run_last   = r_run_last;

    a_frame_ends_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_frame_last |-> r_run_last)
        else $error("frame end without run end");

    a_esc_needs_special: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_ESC) |-> (i_job_valid && special))
        else $error("escape phase on an ordinary byte");

    a_trailer_needs_job: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CHK || r_state == ST_LF) |-> (i_job_valid && i_job.trailer))
        else $error("trailer phase without a closing job");

    a_idx_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_job_valid |-> (r_idx <= i_job.last_idx))
        else $error("byte index past the end of the job");

endmodule

`default_nettype wire

@@ sv/escaped_command_frame_encoder_core.sv @@
// Top level of the escaped command frame encoder.
// A header beat (cmd 0) yields command, page, address high and address low, each escaped
// (0x0A as DB DC, 0xDB as DB DD); a write header (0x77) is followed by page_count+1
// payload beats, any other command is closed at once by the checksum (0x100 minus the
// sum of the bytes sent) and a 0x0A unless the checksum is itself 0x0A. The block emits one
// byte per cycle on the result side while its output is empty or popped; an item makes one to
// four bytes for a payload beat and four to ten for a header. Input beats are taken every
// cycle while the job queue of QUEUE_DEPTH entries has room; the byte serializer sets the
// sustained rate. Payload beats that arrive when no payload is expected are taken and dropped.
`default_nettype none

module escaped_command_frame_encoder_core #(
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         push,
    output logic              full,
    input  wire logic         i_cmd,
    input  wire logic [7:0]   i_command_code,
    input  wire logic [7:0]   i_page_count,
    input  wire logic [15:0]  i_address,
    input  wire logic [7:0]   i_data_byte,
    output logic              empty,
    input  wire logic         pop,
    output logic [7:0]        o_out_byte,
    output logic              o_frame_last,
    output logic              o_run_last
);

    ecfe_pkg::t_job wr_job;
    ecfe_pkg::t_job rd_job;
    logic           job_push;
    logic           job_pop;
    logic           job_valid;
    logic           q_full;

    assign full = q_full;

    ecfe_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .push           (push),
        .i_q_full       (q_full),
        .i_cmd          (i_cmd),
        .i_command_code (i_command_code),
        .i_page_count   (i_page_count),
        .i_address      (i_address),
        .i_data_byte    (i_data_byte),
        .o_job          (wr_job),
        .o_job_push     (job_push)
    );

    ecfe_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_wr     (job_push),
        .i_wr_job (wr_job),
        .i_rd     (job_pop),
        .o_rd_job (rd_job),
        .o_valid  (job_valid),
        .o_full   (q_full)
    );

    ecfe_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_job        (rd_job),
        .i_job_valid  (job_valid),
        .o_job_pop    (job_pop),
        .pop          (pop),
        .empty        (empty),
        .o_out_byte   (o_out_byte),
        .o_frame_last (o_frame_last),
        .o_run_last   (o_run_last)
    );

endmodule

`default_nettype wire

@@ dv/escaped_command_frame_encoder_core_tb.sv @@
// Testbench for the escaped command frame encoder core, checked beat by beat against a predictor.
`timescale 1ns / 100ps

module escaped_command_frame_encoder_core_tb;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       frame_last;
        logic       run_last;
    } t_frame_byte;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        push = 1'b0;
    logic        full;
    logic        i_cmd = ecfe_pkg::CMD_HEADER;
    logic [7:0]  i_command_code = 8'h00;
    logic [7:0]  i_page_count = 8'h00;
    logic [15:0] i_address = 16'h0000;
    logic [7:0]  i_data_byte = 8'h00;
    logic        empty;
    logic        pop = 1'b0;
    logic [7:0]  o_out_byte;
    logic        o_frame_last;
    logic        o_run_last;

    t_frame_byte frame_bytes_due[$];
    t_frame_byte run_bytes[$];
    t_frame_byte next_due;
    logic [7:0]  frame_sum = 8'h00;
    logic [8:0]  payload_remaining = 9'd0;
    int          error_count = 0;
    int          send_idle_pct = 0;
    int          take_idle_pct = 0;
    int          hold_cycles = 0;
    int          counted_items = 0;

    escaped_command_frame_encoder_core DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .push           (push),
        .full           (full),
        .i_cmd          (i_cmd),
        .i_command_code (i_command_code),
        .i_page_count   (i_page_count),
        .i_address      (i_address),
        .i_data_byte    (i_data_byte),
        .empty          (empty),
        .pop            (pop),
        .o_out_byte     (o_out_byte),
        .o_frame_last   (o_frame_last),
        .o_run_last     (o_run_last)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #(200_000 * 20);
        $display("CHECK FAILED");
        $finish;
    end

    function void add_counted(logic [7:0] b);
        frame_sum = frame_sum + b;
        run_bytes.push_back({b, 1'b0, 1'b0});
    endfunction

    function void add_escaped(logic [7:0] b);
        if (b == ecfe_pkg::LINE_END) begin
            add_counted(ecfe_pkg::BYTE_ESC);
            add_counted(ecfe_pkg::ESC_LF);
        end else if (b == ecfe_pkg::BYTE_ESC) begin
            add_counted(ecfe_pkg::BYTE_ESC);
            add_counted(ecfe_pkg::ESC_ESC);
        end else begin
            add_counted(b);
        end
    endfunction

    function void add_trailer();
        logic [7:0] chk;
        chk = 8'h00 - frame_sum;
        if (chk == ecfe_pkg::LINE_END) begin
            run_bytes.push_back({chk, 1'b1, 1'b0});
        end else begin
            run_bytes.push_back({chk, 1'b0, 1'b0});
            run_bytes.push_back({ecfe_pkg::LINE_END, 1'b1, 1'b0});
        end
    endfunction

    function bit predict_frame_bytes(logic cmd, logic [7:0] code, logic [7:0] page,
                                     logic [15:0] addr, logic [7:0] data);
        t_frame_byte last_byte;
        run_bytes.delete();
        if (cmd == ecfe_pkg::CMD_HEADER) begin
            frame_sum = 8'h00;
            payload_remaining = 9'd0;
            add_escaped(code);
            add_escaped(page);
            add_escaped(addr[15:8]);
            add_escaped(addr[7:0]);
            if (code == ecfe_pkg::CODE_WRITE) begin
                payload_remaining = {1'b0, page} + 9'd1;
            end else begin
                add_trailer();
            end
        end else if (payload_remaining != 9'd0) begin
            add_escaped(data);
            payload_remaining = payload_remaining - 9'd1;
            if (payload_remaining == 9'd0) begin
                add_trailer();
            end
        end
        if (run_bytes.size() == 0) begin
            return 1'b0;
        end
        last_byte = run_bytes.pop_back();
        last_byte.run_last = 1'b1;
        run_bytes.push_back(last_byte);
        foreach (run_bytes[k]) begin
            frame_bytes_due.push_back(run_bytes[k]);
        end
        return 1'b1;
    endfunction

    task report_mismatch(string field, logic [7:0] got, logic [7:0] want);
        $display("%0t: mismatch on %s: got %02h, expected %02h", $time, field, got, want);
        error_count++;
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && pop && !empty) begin
            if (frame_bytes_due.size() == 0) begin
                report_mismatch("beat with nothing due", o_out_byte, 8'h00);
            end else begin
                next_due = frame_bytes_due.pop_front();
                if (o_out_byte !== next_due.out_byte) begin
                    report_mismatch("out_byte", o_out_byte, next_due.out_byte);
                end
                if (o_frame_last !== next_due.frame_last) begin
                    report_mismatch("frame_last", {7'd0, o_frame_last},
                                    {7'd0, next_due.frame_last});
                end
                if (o_run_last !== next_due.run_last) begin
                    report_mismatch("run_last", {7'd0, o_run_last}, {7'd0, next_due.run_last});
                end
            end
        end
    end

    always @(negedge i_clk) begin
        if (hold_cycles > 0) begin
            pop <= 1'b0;
            hold_cycles = hold_cycles - 1;
        end else begin
            pop <= ($urandom_range(99) >= take_idle_pct);
        end
    end

    task automatic send_item(logic cmd, logic [7:0] code, logic [7:0] page,
                             logic [15:0] addr, logic [7:0] data);
        while ($urandom_range(99) < send_idle_pct) begin
            @(negedge i_clk);
            push <= 1'b0;
        end
        @(negedge i_clk);
        push           <= 1'b1;
        i_cmd          <= cmd;
        i_command_code <= code;
        i_page_count   <= page;
        i_address      <= addr;
        i_data_byte    <= data;
        @(posedge i_clk);
        while (full) begin
            @(posedge i_clk);
        end
        if (predict_frame_bytes(cmd, code, page, addr, data)) begin
            counted_items++;
        end
    endtask

    task automatic send_header(logic [7:0] code, logic [7:0] page, logic [15:0] addr);
        send_item(ecfe_pkg::CMD_HEADER, code, page, addr, 8'($urandom));
    endtask

    task automatic send_payload(logic [7:0] data);
        send_item(ecfe_pkg::CMD_PAYLOAD, 8'($urandom), 8'($urandom), 16'($urandom), data);
    endtask

    task automatic wait_for_drain();
        @(negedge i_clk);
        push <= 1'b0;
        while (frame_bytes_due.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (12) @(posedge i_clk);
    endtask

    function automatic logic [7:0] pick_data();
        int roll;
        roll = $urandom_range(99);
        if (roll < 15) begin
            return ecfe_pkg::LINE_END;
        end else if (roll < 25) begin
            return ecfe_pkg::BYTE_ESC;
        end
        return 8'($urandom);
    endfunction

    task automatic test_header_extremes();
        send_header(8'h00, 8'h00, 16'h0000);
        send_header(8'hFF, 8'hFF, 16'hFFFF);
        send_header(ecfe_pkg::LINE_END, ecfe_pkg::BYTE_ESC,
                    {ecfe_pkg::LINE_END, ecfe_pkg::BYTE_ESC});
        send_header(ecfe_pkg::BYTE_ESC, ecfe_pkg::LINE_END,
                    {ecfe_pkg::BYTE_ESC, ecfe_pkg::LINE_END});
        // The checksum of this frame is itself a line end, so no line end follows it.
        send_header(8'h00, 8'h00, 16'h00F6);
        wait_for_drain();
    endtask

    task automatic test_write_frames();
        send_header(ecfe_pkg::CODE_WRITE, 8'h00, 16'h0000);
        send_payload(ecfe_pkg::LINE_END);
        send_header(ecfe_pkg::CODE_WRITE, 8'h01, 16'hDB0A);
        send_payload(ecfe_pkg::BYTE_ESC);
        send_payload(8'hFF);
        send_header(ecfe_pkg::CODE_WRITE, 8'h00, 16'h0000);
        send_payload(8'h7F);
        send_header(ecfe_pkg::CODE_WRITE, 8'h02, 16'h1234);
        send_payload(8'h00);
        send_payload(8'hFF);
        send_payload(ecfe_pkg::LINE_END);
        wait_for_drain();
    endtask

    task automatic test_stray_payload();
        send_payload(8'($urandom));
        send_header(8'h01, 8'h10, 16'hA55A);
        send_payload(ecfe_pkg::LINE_END);
        send_payload(8'($urandom));
        send_header(8'h02, 8'h20, 16'h5AA5);
        wait_for_drain();
    endtask

    task automatic test_header_abandons_payload();
        send_header(ecfe_pkg::CODE_WRITE, 8'h03, 16'h0102);
        send_payload(8'h55);
        send_header(ecfe_pkg::CODE_WRITE, 8'h00, 16'h0304);
        send_payload(ecfe_pkg::BYTE_ESC);
        send_header(8'h52, 8'h00, 16'h0506);
        wait_for_drain();
    endtask

    task automatic send_random_frame();
        int         roll;
        int         payload_beats;
        logic [7:0] code;
        logic [7:0] page;
        roll = $urandom_range(99);
        if (roll < 10) begin
            send_item(1'($urandom), 8'($urandom), 8'($urandom), 16'($urandom), 8'($urandom));
        end else begin
            code = (roll < 75) ? ecfe_pkg::CODE_WRITE : 8'($urandom);
            page = ($urandom_range(9) == 0) ? 8'($urandom_range(31)) : 8'($urandom_range(3));
            send_header(code, page, {pick_data(), pick_data()});
            if (code == ecfe_pkg::CODE_WRITE) begin
                payload_beats = page + 1;
                if ($urandom_range(19) == 0) begin
                    payload_beats = $urandom_range(page);
                end
                repeat (payload_beats) send_payload(pick_data());
            end
        end
    endtask

    task automatic test_random_traffic(int send_pct, int take_pct, int beats);
        int start_count;
        send_idle_pct = send_pct;
        take_idle_pct = take_pct;
        start_count = counted_items;
        while (counted_items - start_count < beats) begin
            send_random_frame();
        end
        wait_for_drain();
    endtask

    task automatic test_backpressure();
        send_idle_pct = 0;
        take_idle_pct = 0;
        @(posedge i_clk);
        hold_cycles = 80;
        send_header(ecfe_pkg::CODE_WRITE, 8'h0F, {ecfe_pkg::LINE_END, ecfe_pkg::BYTE_ESC});
        repeat (16) send_payload(ecfe_pkg::LINE_END);
        wait_for_drain();
    endtask

    task automatic test_longest_write();
        send_idle_pct = 0;
        take_idle_pct = 0;
        send_header(ecfe_pkg::CODE_WRITE, 8'hFF, 16'($urandom));
        repeat (20) send_payload(pick_data());
        send_header(8'h01, 8'h00, 16'($urandom));
        wait_for_drain();
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_header_extremes();
        test_write_frames();
        test_stray_payload();
        test_header_abandons_payload();
        test_random_traffic(36, 73, 65);
        test_random_traffic(73, 36, 65);
        test_random_traffic(0, 0, 65);
        test_backpressure();
        test_longest_write();
        if (error_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

@@ sim.f @@
sv/ecfe_pkg.sv
sv/ecfe_front.sv
sv/ecfe_fifo.sv
sv/ecfe_back.sv
sv/escaped_command_frame_encoder_core.sv
dv/escaped_command_frame_encoder_core_tb.sv
